/* hdl/saws_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saws_pkg
// Shared types and constants of the stop-and-wait segmenting sender.
// ----------------------------------------------------------------------------
package saws_pkg;

    localparam int unsigned LEN_W    = 32;
    localparam int unsigned SEG_W    = 16;
    localparam int unsigned CNT_W    = 8;
    localparam int unsigned TICK_W   = 32;
    localparam int unsigned HDR_W    = 6;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 32;

    localparam logic [7:0]       HDR_ZERO    = 8'd48;
    localparam logic [7:0]       ACK_DELTA   = 8'd2;
    localparam logic [HDR_W-2:0] HDR_PREFIX  = 5'b11000;
    localparam logic [CNT_W-1:0] CNT_MAX     = 8'hFF;

    localparam logic [SEG_W-1:0]  SEG_RESET     = 16'd1024;
    localparam logic [CNT_W-1:0]  RETRY_RESET   = 8'd10;
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 32'd1000;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_ACK   = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ACT_SEND = 2'd0,
        ACT_DONE = 2'd1,
        ACT_FAIL = 2'd2
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEGMENT_BYTES = 2'd0,
        CFG_RETRY_LIMIT   = 2'd1,
        CFG_TIMEOUT_TICKS = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]       command;
        logic [LEN_W-1:0] transfer_length;
        logic [7:0]       reply_byte;
    } t_item;

    typedef struct packed {
        logic [1:0]       action;
        logic [HDR_W-1:0] header_byte;
        logic [LEN_W-1:0] segment_offset;
        logic [SEG_W-1:0] segment_length;
        logic [CNT_W-1:0] attempt_count;
    } t_result;

    typedef struct packed {
        logic [SEG_W-1:0]  segment_bytes;
        logic [CNT_W-1:0]  retry_limit;
        logic [TICK_W-1:0] timeout_ticks;
    } t_cfg;

endpackage

/* hdl/saws_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saws_in_if
// Command channel: one item per valid/ready handshake.
// ----------------------------------------------------------------------------
interface saws_in_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  command;
    logic [saws_pkg::LEN_W-1:0]  transfer_length;
    logic [7:0]                  reply_byte;

    modport source (output valid, output command, output transfer_length,
                    output reply_byte, input ready);
    modport sink   (input valid, input command, input transfer_length,
                    input reply_byte, output ready);
endinterface

/* hdl/saws_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saws_out_if
// Result channel: one item per valid/ready handshake.
// ----------------------------------------------------------------------------
interface saws_out_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  action;
    logic [saws_pkg::HDR_W-1:0]  header_byte;
    logic [saws_pkg::LEN_W-1:0]  segment_offset;
    logic [saws_pkg::SEG_W-1:0]  segment_length;
    logic [saws_pkg::CNT_W-1:0]  attempt_count;

    modport source (output valid, output action, output header_byte,
                    output segment_offset, output segment_length,
                    output attempt_count, input ready);
    modport sink   (input valid, input action, input header_byte,
                    input segment_offset, input segment_length,
                    input attempt_count, output ready);
endinterface

/* hdl/saws_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saws_cfg_if
// Register write channel: index and data per valid/ready handshake.
// ----------------------------------------------------------------------------
interface saws_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [saws_pkg::CFG_IDX_W-1:0]  index;
    logic [saws_pkg::CFG_DAT_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/saws_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saws_engine
// Sender state and single-pass step logic for one registered item.
// ----------------------------------------------------------------------------
module saws_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  saws_pkg::t_item   i_item,
    input  saws_pkg::t_cfg    i_cfg,
    output logic              o_result_valid,
    output saws_pkg::t_result o_result
);

    logic                           r_busy;
    logic                           r_seq;
    logic [saws_pkg::LEN_W-1:0]     r_offset;
    logic [saws_pkg::LEN_W-1:0]     r_left;
    logic [saws_pkg::SEG_W-1:0]     r_cur_len;
    logic [saws_pkg::CNT_W-1:0]     r_fails;
    logic [saws_pkg::TICK_W-1:0]    r_wait;

    logic                           n_busy;
    logic                           n_seq;
    logic [saws_pkg::LEN_W-1:0]     n_offset;
    logic [saws_pkg::LEN_W-1:0]     n_left;
    logic [saws_pkg::SEG_W-1:0]     n_cur_len;
    logic [saws_pkg::CNT_W-1:0]     n_fails;
    logic [saws_pkg::TICK_W-1:0]    n_wait;

    logic [saws_pkg::SEG_W-1:0]     seg_eff;
    logic [saws_pkg::TICK_W-1:0]    limit_eff;
    logic [saws_pkg::CNT_W-1:0]     fails_inc;
    logic                           fails_over;
    logic [saws_pkg::TICK_W-1:0]    wait_inc;
    logic [saws_pkg::LEN_W-1:0]     left_after;
    logic [saws_pkg::LEN_W-1:0]     offset_after;
    logic [saws_pkg::SEG_W-1:0]     len_after;
    logic [saws_pkg::SEG_W-1:0]     len_start;
    logic [7:0]                     ack_expect;
    logic                           res_valid;
    logic [1:0]                     res_action;
    logic                           res_seq;

    always_comb begin
        seg_eff      = (i_cfg.segment_bytes == '0) ? saws_pkg::SEG_W'(1)
                                                  : i_cfg.segment_bytes;
        limit_eff    = (i_cfg.timeout_ticks == '0) ? saws_pkg::TICK_W'(1)
                                                  : i_cfg.timeout_ticks;
        fails_inc    = (r_fails != saws_pkg::CNT_MAX) ? r_fails + 1'b1 : r_fails;
        fails_over   = (fails_inc >= i_cfg.retry_limit);
        wait_inc     = r_wait + 1'b1;
        left_after   = r_left - saws_pkg::LEN_W'(r_cur_len);
        offset_after = r_offset + saws_pkg::LEN_W'(r_cur_len);
        len_after    = (left_after >= saws_pkg::LEN_W'(seg_eff))
                       ? seg_eff : left_after[saws_pkg::SEG_W-1:0];
        len_start    = (i_item.transfer_length >= saws_pkg::LEN_W'(seg_eff))
                       ? seg_eff : i_item.transfer_length[saws_pkg::SEG_W-1:0];
        ack_expect   = saws_pkg::HDR_ZERO + saws_pkg::ACK_DELTA + 8'(r_seq);
    end

    always_comb begin
        n_busy     = r_busy;
        n_seq      = r_seq;
        n_offset   = r_offset;
        n_left     = r_left;
        n_cur_len  = r_cur_len;
        n_fails    = r_fails;
        n_wait     = r_wait;
        res_valid  = 1'b0;
        res_action = saws_pkg::ACT_SEND;
        res_seq    = 1'b0;
        unique case (i_item.command)
            saws_pkg::CMD_START: begin
                n_busy    = 1'b1;
                n_seq     = 1'b0;
                n_offset  = '0;
                n_left    = i_item.transfer_length;
                n_cur_len = len_start;
                n_fails   = '0;
                n_wait    = '0;
                res_valid = 1'b1;
            end
            saws_pkg::CMD_TICK: begin
                if (r_busy) begin
                    if (wait_inc >= limit_eff) begin
                        n_fails    = fails_inc;
                        n_wait     = '0;
                        res_valid  = 1'b1;
                        if (fails_over) begin
                            n_busy     = 1'b0;
                            res_action = saws_pkg::ACT_FAIL;
                        end
                    end else begin
                        n_wait = wait_inc;
                    end
                end
            end
            saws_pkg::CMD_ACK: begin
                if (r_busy) begin
                    res_valid = 1'b1;
                    if (i_item.reply_byte == ack_expect) begin
                        n_seq = ~r_seq;
                        if (r_cur_len < seg_eff) begin
                            // short segment acknowledged: report it with its own header
                            n_busy     = 1'b0;
                            res_action = saws_pkg::ACT_DONE;
                            res_seq    = 1'b1;
                        end else begin
                            n_offset  = offset_after;
                            n_left    = left_after;
                            n_cur_len = len_after;
                            n_fails   = '0;
                            n_wait    = '0;
                        end
                    end else begin
                        n_fails = fails_inc;
                        n_wait  = '0;
                        if (fails_over) begin
                            n_busy     = 1'b0;
                            res_action = saws_pkg::ACT_FAIL;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_result_valid                = res_valid;
        o_result.action               = res_action;
        o_result.header_byte          = {saws_pkg::HDR_PREFIX, res_seq ? r_seq : n_seq};
        o_result.segment_offset       = n_offset;
        o_result.segment_length       = n_cur_len;
        o_result.attempt_count        = n_fails;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_seq     <= 1'b0;
            r_offset  <= '0;
            r_left    <= '0;
            r_cur_len <= '0;
            r_fails   <= '0;
            r_wait    <= '0;
        end else if (i_advance) begin
            r_busy    <= n_busy;
            r_seq     <= n_seq;
            r_offset  <= n_offset;
            r_left    <= n_left;
            r_cur_len <= n_cur_len;
            r_fails   <= n_fails;
            r_wait    <= n_wait;
        end
    end

endmodule

/* hdl/stop_and_wait_sender.sv */
`timescale 1ns / 1ps
// Path: an accepted item is held in the input register, then its result in the result
//   register; items that cause no result leave nothing behind.
// Throughput: one item per cycle, set by the single-pass step between the two
//   registers; a stalled result register holds the input register in turn.
// Reset: synchronous, active low; sender idle, counters clear, registers at defaults.
// ----------------------------------------------------------------------------
// stop_and_wait_sender
// Alternating-bit stop-and-wait sender that cuts a transfer into segments.
// ----------------------------------------------------------------------------
module stop_and_wait_sender (
    input  logic        i_clk,
    input  logic        i_rst_n,
    saws_in_if.sink     i_item,
    saws_cfg_if.sink    i_cfg,
    saws_out_if.source  o_result
);

    logic              r_in_valid;
    saws_pkg::t_item   r_item;
    logic              r_out_valid;
    saws_pkg::t_result r_out;
    saws_pkg::t_cfg    r_cfg;

    logic              n_in_valid;
    logic              n_out_valid;
    logic              advance;
    logic              in_accept;
    logic              eng_valid;
    saws_pkg::t_result eng_result;

    assign advance      = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || advance;
    assign in_accept    = i_item.valid && i_item.ready;
    assign i_cfg.ready  = 1'b1;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (advance && eng_valid) begin
            n_out_valid = 1'b1;
        end else if (o_result.ready) begin
            n_out_valid = 1'b0;
        end
    end

    saws_engine u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (advance),
        .i_item         (r_item),
        .i_cfg          (r_cfg),
        .o_result_valid (eng_valid),
        .o_result       (eng_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.command         <= i_item.command;
            r_item.transfer_length <= i_item.transfer_length;
            r_item.reply_byte      <= i_item.reply_byte;
        end
        if (advance && eng_valid) begin
            r_out <= eng_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.segment_bytes <= saws_pkg::SEG_RESET;
            r_cfg.retry_limit   <= saws_pkg::RETRY_RESET;
            r_cfg.timeout_ticks <= saws_pkg::TIMEOUT_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                saws_pkg::CFG_SEGMENT_BYTES:
                    r_cfg.segment_bytes <= i_cfg.data[saws_pkg::SEG_W-1:0];
                saws_pkg::CFG_RETRY_LIMIT:
                    r_cfg.retry_limit   <= i_cfg.data[saws_pkg::CNT_W-1:0];
                saws_pkg::CFG_TIMEOUT_TICKS:
                    r_cfg.timeout_ticks <= i_cfg.data[saws_pkg::TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.action         = r_out.action;
    assign o_result.header_byte    = r_out.header_byte;
    assign o_result.segment_offset = r_out.segment_offset;
    assign o_result.segment_length = r_out.segment_length;
    assign o_result.attempt_count  = r_out.attempt_count;

    a_start_opens_segment: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_item.command == saws_pkg::CMD_START
        |=> r_out_valid && r_out.segment_offset == '0 && r_out.attempt_count == '0
            && r_out.header_byte == saws_pkg::HDR_ZERO[saws_pkg::HDR_W-1:0])
        else $error("start did not open the first segment");

    a_header_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.header_byte[saws_pkg::HDR_W-1:1] == saws_pkg::HDR_PREFIX)
        else $error("header byte outside sequence characters");

    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_item))
        else $error("pending item lost while stalled");

    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_result.ready |=> r_out_valid && $stable(r_out))
        else $error("waiting result overwritten");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stop-and-wait segmenting sender. Commands go in
// on the item channel and each accepted one is run through a local model of
// the sender; any segment, done or failure it predicts is queued and compared
// field by field with what the block returns. Directed checks cover the reset
// registers, the register extremes and the attempt ceiling, then random
// transfers run under several patterns of source idling and sink stalling.
// ----------------------------------------------------------------------------
module testbench;
    import saws_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 4;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_CYCLES    = 500000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    saws_in_if  item_if ();
    saws_cfg_if cfg_if ();
    saws_out_if result_if ();

    stop_and_wait_sender DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .i_cfg    (cfg_if),
        .o_result (result_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // register copy
    logic [SEG_W-1:0]  cfg_seg     = SEG_RESET;
    logic [CNT_W-1:0]  cfg_retry   = RETRY_RESET;
    logic [TICK_W-1:0] cfg_timeout = TIMEOUT_RESET;

    // sender state copy
    bit                st_busy   = 1'b0;
    bit                st_seq    = 1'b0;
    logic [LEN_W-1:0]  st_offset = '0;
    logic [LEN_W-1:0]  st_left   = '0;
    logic [SEG_W-1:0]  st_len    = '0;
    logic [CNT_W-1:0]  st_fails  = '0;
    logic [TICK_W-1:0] st_waited = '0;

    t_result expected_segments[$];
    int      mismatches     = 0;
    int      useful_items   = 0;
    int      cycle_count    = 0;
    int      send_idle_pct  = 0;
    int      recv_stall_pct = 0;

    function automatic logic [SEG_W-1:0] full_segment();
        return (cfg_seg == '0) ? SEG_W'(1) : cfg_seg;
    endfunction

    function automatic logic [7:0] ack_byte();
        return HDR_ZERO + ACK_DELTA + 8'(st_seq);
    endfunction

    function automatic t_result make_result(input t_action act);
        t_result r;
        r.action         = act;
        r.header_byte    = 6'(HDR_ZERO + 8'(st_seq));
        r.segment_offset = st_offset;
        r.segment_length = st_len;
        r.attempt_count  = st_fails;
        return r;
    endfunction

    function automatic void load_segment();
        logic [SEG_W-1:0] seg;
        seg       = full_segment();
        st_len    = (st_left >= LEN_W'(seg)) ? seg : st_left[SEG_W-1:0];
        st_fails  = '0;
        st_waited = '0;
    endfunction

    function automatic t_result count_failure();
        if (st_fails != CNT_MAX) st_fails++;
        st_waited = '0;
        if (st_fails >= cfg_retry) begin
            st_busy = 1'b0;
            return make_result(ACT_FAIL);
        end
        return make_result(ACT_SEND);
    endfunction

    function automatic bit advance_sender(input logic [1:0] cmd, input logic [LEN_W-1:0] len,
                                          input logic [7:0] reply, output t_result r);
        logic [TICK_W-1:0] limit;
        r = '0;
        if (cmd == CMD_START) begin
            st_busy   = 1'b1;
            st_seq    = 1'b0;
            st_offset = '0;
            st_left   = len;
            load_segment();
            r = make_result(ACT_SEND);
            return 1'b1;
        end
        if (!st_busy) return 1'b0;
        if (cmd == CMD_TICK) begin
            limit = (cfg_timeout == '0) ? TICK_W'(1) : cfg_timeout;
            st_waited++;
            if (st_waited >= limit) begin
                r = count_failure();
                return 1'b1;
            end
            return 1'b0;
        end
        if (cmd == CMD_ACK) begin
            if (reply == ack_byte()) begin
                if (st_len < full_segment()) begin
                    r       = make_result(ACT_DONE);
                    st_seq  = ~st_seq;
                    st_busy = 1'b0;
                    return 1'b1;
                end
                st_seq    = ~st_seq;
                st_offset = st_offset + LEN_W'(st_len);
                st_left   = st_left - LEN_W'(st_len);
                load_segment();
                r = make_result(ACT_SEND);
                return 1'b1;
            end
            r = count_failure();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic send_item(input logic [1:0] cmd, input logic [LEN_W-1:0] len,
                             input logic [7:0] reply);
        t_result r;
        bit      was_busy;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            item_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_if.valid           <= 1'b1;
        item_if.command         <= cmd;
        item_if.transfer_length <= len;
        item_if.reply_byte      <= reply;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        was_busy = st_busy;
        if (cmd == CMD_START || was_busy) useful_items++;
        if (advance_sender(cmd, len, reply, r)) expected_segments.push_back(r);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        item_if.valid <= 1'b0;
        while (expected_segments.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [CFG_DAT_W-1:0] value);
        logic [CFG_DAT_W-1:0] word;
        case (idx)
            CFG_SEGMENT_BYTES: word = {16'($urandom), value[SEG_W-1:0]};
            CFG_RETRY_LIMIT:   word = {24'($urandom), value[CNT_W-1:0]};
            default:           word = value;
        endcase
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= word;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        case (idx)
            CFG_SEGMENT_BYTES: cfg_seg     = word[SEG_W-1:0];
            CFG_RETRY_LIMIT:   cfg_retry   = word[CNT_W-1:0];
            CFG_TIMEOUT_TICKS: cfg_timeout = word[TICK_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (expected_segments.size() == 0) begin
                mismatches++;
                $display("%0t: result with none expected: expected nothing, actual %0h %0h %0h %0h %0h",
                         $time, result_if.action, result_if.header_byte,
                         result_if.segment_offset, result_if.segment_length,
                         result_if.attempt_count);
            end else begin
                want = expected_segments.pop_front();
                check_field("action", 32'(want.action), 32'(result_if.action));
                check_field("header_byte", 32'(want.header_byte), 32'(result_if.header_byte));
                check_field("segment_offset", want.segment_offset, result_if.segment_offset);
                check_field("segment_length", 32'(want.segment_length),
                            32'(result_if.segment_length));
                check_field("attempt_count", 32'(want.attempt_count),
                            32'(result_if.attempt_count));
            end
        end
    end

    always @(negedge i_clk) begin
        result_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES) begin
            $display("** stop_and_wait_sender: FAILED **");
            $finish;
        end
    end

    task automatic test_default_registers();
        send_item(CMD_TICK, 32'($urandom), 8'($urandom));
        send_item(CMD_ACK, 32'($urandom), HDR_ZERO + ACK_DELTA);
        send_item(2'd3, 32'($urandom), 8'($urandom));
        send_item(CMD_START, 32'd2048, 8'($urandom));
        send_item(CMD_ACK, 32'($urandom), HDR_ZERO + ACK_DELTA + 8'd1);
        send_item(2'd3, 32'($urandom), 8'($urandom));
        send_item(CMD_ACK, 32'($urandom), ack_byte());
        send_item(CMD_ACK, 32'($urandom), ack_byte());
        send_item(CMD_ACK, 32'($urandom), ack_byte());
        send_item(CMD_ACK, 32'($urandom), ack_byte());
        wait_idle();
    endtask

    task automatic test_register_extremes();
        write_register(CFG_SEGMENT_BYTES, '0);
        write_register(CFG_RETRY_LIMIT, '0);
        write_register(CFG_TIMEOUT_TICKS, '0);
        send_item(CMD_START, 32'hFFFF_FFFF, 8'($urandom));
        send_item(CMD_TICK, 32'($urandom), 8'($urandom));
        send_item(CMD_START, 32'd0, 8'($urandom));
        send_item(CMD_ACK, 32'($urandom), 8'hFF);
        wait_idle();
        write_register(CFG_SEGMENT_BYTES, 32'd65535);
        write_register(CFG_RETRY_LIMIT, 32'd1);
        write_register(CFG_TIMEOUT_TICKS, 32'hFFFF_FFFF);
        send_item(CMD_START, 32'hFFFF_FFFF, 8'h00);
        send_item(CMD_ACK, 32'($urandom), ack_byte());
        send_item(CMD_TICK, 32'($urandom), 8'($urandom));
        send_item(CMD_START, 32'd5, 8'($urandom));
        send_item(CMD_ACK, 32'($urandom), ack_byte());
        send_item(CMD_START, 32'd65535, 8'($urandom));
        send_item(CMD_ACK, 32'($urandom), ack_byte());
        send_item(CMD_ACK, 32'($urandom), ack_byte());
        wait_idle();
    endtask

    task automatic test_attempt_ceiling();
        write_register(CFG_SEGMENT_BYTES, 32'd4);
        write_register(CFG_RETRY_LIMIT, 32'd255);
        write_register(CFG_TIMEOUT_TICKS, 32'd1);
        send_item(CMD_START, 32'd10, 8'($urandom));
        repeat (255) send_item(CMD_TICK, 32'($urandom), 8'($urandom));
        wait_idle();
    endtask

    task automatic run_transfer();
        logic [SEG_W-1:0] seg;
        logic [LEN_W-1:0] len;
        int               steps;
        int               pick;
        seg = full_segment();
        repeat ($urandom_range(0, 2))
            send_item(2'($urandom_range(1, 3)), 32'($urandom), 8'($urandom));
        case ($urandom_range(0, 9))
            0:       len = 32'($urandom);
            1:       len = '0;
            2:       len = 32'hFFFF_FFFF;
            3:       len = LEN_W'(seg) * $urandom_range(1, 4);
            default: len = LEN_W'(seg) * $urandom_range(0, 3) + $urandom_range(0, seg - 1);
        endcase
        send_item(CMD_START, len, 8'($urandom));
        steps = 0;
        while (st_busy && steps < 40) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                send_item(CMD_ACK, 32'($urandom), ack_byte());
            else if (pick < 72)
                send_item(CMD_TICK, 32'($urandom), 8'($urandom));
            else if (pick < 80)
                send_item(CMD_ACK, 32'($urandom), ack_byte() ^ 8'h01);
            else if (pick < 88)
                send_item(CMD_ACK, 32'($urandom), 8'($urandom));
            else if (pick < 91)
                send_item(CMD_START, 32'($urandom_range(0, 3 * seg)), 8'($urandom));
            else if (pick < 95)
                send_item(2'd3, 32'($urandom), 8'($urandom));
            else
                send_item(2'($urandom), 32'($urandom), 8'($urandom));
            steps++;
        end
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int target);
        int first;
        int transfers;
        first          = useful_items;
        transfers      = 0;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (useful_items - first < target) begin
            if (transfers % 6 == 0) begin
                wait_idle();
                case ($urandom_range(0, 9))
                    0:       write_register(CFG_SEGMENT_BYTES, '0);
                    1:       write_register(CFG_SEGMENT_BYTES, 32'd1);
                    2:       write_register(CFG_SEGMENT_BYTES, 32'd65535);
                    3, 4:    write_register(CFG_SEGMENT_BYTES, $urandom_range(2, 8));
                    5, 6:    write_register(CFG_SEGMENT_BYTES, $urandom_range(1, 64));
                    7:       write_register(CFG_SEGMENT_BYTES, $urandom_range(1, 1024));
                    8:       write_register(CFG_SEGMENT_BYTES, $urandom);
                    default: write_register(CFG_SEGMENT_BYTES, 32'd3);
                endcase
                case ($urandom_range(0, 5))
                    0:       write_register(CFG_RETRY_LIMIT, '0);
                    1:       write_register(CFG_RETRY_LIMIT, 32'd1);
                    2:       write_register(CFG_RETRY_LIMIT, 32'd255);
                    default: write_register(CFG_RETRY_LIMIT, $urandom_range(1, 6));
                endcase
                case ($urandom_range(0, 6))
                    0:       write_register(CFG_TIMEOUT_TICKS, '0);
                    1:       write_register(CFG_TIMEOUT_TICKS, 32'd1);
                    2:       write_register(CFG_TIMEOUT_TICKS, 32'hFFFF_FFFF);
                    3:       write_register(CFG_TIMEOUT_TICKS, $urandom);
                    default: write_register(CFG_TIMEOUT_TICKS, $urandom_range(1, 6));
                endcase
            end
            run_transfer();
            transfers++;
        end
        wait_idle();
    endtask

    initial begin
        item_if.valid           = 1'b0;
        item_if.command         = CMD_START;
        item_if.transfer_length = '0;
        item_if.reply_byte      = '0;
        cfg_if.valid            = 1'b0;
        cfg_if.index            = CFG_SEGMENT_BYTES;
        cfg_if.data             = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_registers();
        test_register_extremes();
        test_attempt_ceiling();
        test_random_traffic(0, 0, 320);
        test_random_traffic(79, 0, 290);
        test_random_traffic(0, 79, 290);
        test_random_traffic(25, 25, 290);

        recv_stall_pct = 0;
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("** stop_and_wait_sender: PASSED **");
        end else begin
            $display("** stop_and_wait_sender: FAILED **");
        end
        $finish;
    end
endmodule

/* filelist.f */
hdl/saws_pkg.sv
hdl/saws_in_if.sv
hdl/saws_out_if.sv
hdl/saws_cfg_if.sv
hdl/saws_engine.sv
hdl/stop_and_wait_sender.sv
tb/testbench.sv
